FILE: sv/mtd_pkg.sv
package mtd_pkg;

    localparam int OPERAND_BITS = 16;
    localparam int FIELD_BITS   = 16;
    localparam int CNT_BITS     = $clog2(OPERAND_BITS + 1);
    localparam int SQ_BITS      = 2 * OPERAND_BITS;

    typedef logic [OPERAND_BITS-1:0] t_operand;
    typedef logic [FIELD_BITS-1:0]   t_field;
    typedef logic [SQ_BITS-1:0]      t_square;

    typedef struct packed {
        t_operand quotient;
        t_operand remainder;
    } t_div_res;

endpackage

FILE: sv/mtd_div.sv
module mtd_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  mtd_pkg::t_operand  i_dividend,
    input  mtd_pkg::t_operand  i_divisor,
    output logic               o_done,
    output mtd_pkg::t_div_res  o_res
);

    logic [mtd_pkg::CNT_BITS-1:0]     r_cnt;
    logic                             r_done;
    mtd_pkg::t_operand                r_quo;
    mtd_pkg::t_operand                r_rem;
    mtd_pkg::t_operand                r_div;

    logic [mtd_pkg::OPERAND_BITS:0]   w_shift;
    logic [mtd_pkg::OPERAND_BITS:0]   w_diff;
    logic                             w_ge;
    mtd_pkg::t_operand                n_rem;
    mtd_pkg::t_operand                n_quo;

    // one restoring step per cycle
    always_comb begin
        w_shift = {r_rem, r_quo[mtd_pkg::OPERAND_BITS-1]};
        w_ge    = w_shift >= {1'b0, r_div};
        w_diff  = w_shift - {1'b0, r_div};
        n_rem   = w_ge ? w_diff[mtd_pkg::OPERAND_BITS-1:0]
                       : w_shift[mtd_pkg::OPERAND_BITS-1:0];
        n_quo   = {r_quo[mtd_pkg::OPERAND_BITS-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo <= i_dividend;
                r_rem <= '0;
                r_div <= i_divisor;
                r_cnt <= mtd_pkg::CNT_BITS'(mtd_pkg::OPERAND_BITS);
            end else if (r_cnt != '0) begin
                r_quo  <= n_quo;
                r_rem  <= n_rem;
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == mtd_pkg::CNT_BITS'(1));
            end
        end
    end

    assign o_done          = r_done;
    assign o_res.quotient  = r_quo;
    assign o_res.remainder = r_rem;

endmodule

FILE: sv/modulus_and_trial_division_prime_test_unit.sv
// Remainder and trial-division prime test.
// Input channel: an item is taken at a clock edge with start high and busy
// low. i_mode selects the operation: 0 gives i_first_operand mod
// i_second_operand, 1 tests i_first_operand for a proper divisor.
// Output channel: o_done is high for exactly one cycle with all result
// fields valid; the receiver cannot stall, so o_done is never held.
// Sequence:
//   zero divisor or tested number below two: result in the cycle after accept
//   mode 0 division: the divider starts at accept, and S_DIV registers its
//   remainder when it is done; mode 1: an S_CHECK step, then a division in
//   S_TRIAL, for each trial divisor d = 2, 3 and up while d*d <= n (at most 254)
// All division goes through one shared restoring divider that retires one
// quotient bit per cycle; the trial square is kept by adding 2d + 1.
// busy stays high from accept until the cycle in which o_done rises; a new
// item may be started in the o_done cycle. One item is in work at a time.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops
// o_done and busy; any item in work is dropped.
module modulus_and_trial_division_prime_test_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_mode,
    input  mtd_pkg::t_field  i_first_operand,
    input  mtd_pkg::t_field  i_second_operand,
    output logic             o_done,
    output mtd_pkg::t_field  o_remainder,
    output logic             o_divide_by_zero,
    output logic             o_is_composite,
    output mtd_pkg::t_field  o_largest_divisor,
    output mtd_pkg::t_field  o_cofactor,
    output logic             o_below_two
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_TRIAL
    } t_state;

    t_state             r_state;
    logic               r_done;
    mtd_pkg::t_field    r_remainder;
    logic               r_divide_by_zero;
    logic               r_is_composite;
    mtd_pkg::t_field    r_largest_divisor;
    mtd_pkg::t_field    r_cofactor;
    logic               r_below_two;
    mtd_pkg::t_operand  r_num;
    mtd_pkg::t_operand  r_d;
    mtd_pkg::t_square   r_sq;

    mtd_pkg::t_operand  w_a;
    mtd_pkg::t_operand  w_b;
    logic               w_accept;
    logic               w_in_range;
    logic               w_div_start;
    mtd_pkg::t_operand  w_dividend;
    mtd_pkg::t_operand  w_divisor;
    logic               w_div_done;
    mtd_pkg::t_div_res  w_div_res;
    mtd_pkg::t_square   n_sq;

    assign w_a        = mtd_pkg::OPERAND_BITS'(i_first_operand);
    assign w_b        = mtd_pkg::OPERAND_BITS'(i_second_operand);
    assign w_accept   = start && (r_state == S_IDLE);
    assign w_in_range = r_sq <= mtd_pkg::SQ_BITS'(r_num);
    assign n_sq       = r_sq + {{(mtd_pkg::OPERAND_BITS-1){1'b0}}, r_d, 1'b0}
                             + mtd_pkg::SQ_BITS'(1);

    always_comb begin
        if (r_state == S_IDLE) begin
            w_div_start = w_accept && !i_mode && (w_b != '0);
            w_dividend  = w_a;
            w_divisor   = w_b;
        end else begin
            w_div_start = (r_state == S_CHECK) && w_in_range;
            w_dividend  = r_num;
            w_divisor   = r_d;
        end
    end

    mtd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_res      (w_div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_remainder       <= '0;
                        r_divide_by_zero  <= 1'b0;
                        r_is_composite    <= 1'b0;
                        r_largest_divisor <= '0;
                        r_cofactor        <= '0;
                        r_below_two       <= 1'b0;
                        if (!i_mode) begin
                            if (w_b == '0) begin
                                r_divide_by_zero <= 1'b1;
                                r_done           <= 1'b1;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end else if (w_a < mtd_pkg::OPERAND_BITS'(2)) begin
                            r_below_two <= 1'b1;
                            r_done      <= 1'b1;
                        end else begin
                            r_num   <= w_a;
                            r_d     <= mtd_pkg::OPERAND_BITS'(2);
                            r_sq    <= mtd_pkg::SQ_BITS'(4);
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_remainder <= mtd_pkg::FIELD_BITS'(w_div_res.remainder);
                        r_done      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_CHECK: begin
                    if (w_in_range) begin
                        r_state <= S_TRIAL;
                    end else begin
                        // no divisor up to the square root: prime
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_TRIAL: begin
                    if (w_div_done) begin
                        if (w_div_res.remainder == '0) begin
                            r_is_composite    <= 1'b1;
                            r_largest_divisor <= mtd_pkg::FIELD_BITS'(w_div_res.quotient);
                            r_cofactor        <= mtd_pkg::FIELD_BITS'(r_d);
                            r_done            <= 1'b1;
                            r_state           <= S_IDLE;
                        end else begin
                            r_d     <= r_d + 1'b1;
                            r_sq    <= n_sq;
                            r_state <= S_CHECK;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_remainder       = r_remainder;
    assign o_divide_by_zero  = r_divide_by_zero;
    assign o_is_composite    = r_is_composite;
    assign o_largest_divisor = r_largest_divisor;
    assign o_cofactor        = r_cofactor;
    assign o_below_two       = r_below_two;

endmodule

FILE: sv/mtd_checker.sv
module mtd_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             i_mode,
    input mtd_pkg::t_field  i_first_operand,
    input mtd_pkg::t_field  i_second_operand,
    input logic             o_done,
    input mtd_pkg::t_field  o_remainder,
    input logic             o_divide_by_zero,
    input logic             o_is_composite,
    input mtd_pkg::t_field  o_largest_divisor,
    input mtd_pkg::t_field  o_cofactor,
    input logic             o_below_two
);

    // zero divisor answers in the next cycle
    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_mode && (i_second_operand == '0)
        |=> o_done && o_divide_by_zero && !busy && (o_remainder == '0))
        else $error("zero divisor item not answered at once");

    // tested number below two answers in the next cycle
    a_below_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_mode && (i_first_operand < mtd_pkg::FIELD_BITS'(2))
        |=> o_done && o_below_two && !busy && !o_is_composite)
        else $error("below two item not answered at once");

    // a real division keeps the block busy
    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_mode && (i_second_operand != '0)
        |=> busy && !o_done)
        else $error("division item did not hold busy");

    // result strobe only when idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result while busy");

    // composite result carries a divisor pair and no other flags
    a_composite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_is_composite
        |-> (o_largest_divisor != '0) && (o_cofactor != '0)
            && !o_below_two && !o_divide_by_zero)
        else $error("inconsistent composite result");

endmodule

bind modulus_and_trial_division_prime_test_unit mtd_checker u_mtd_checker (.*);
